### src/opt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_pkg
// Shared types and constants for the OLED page transpose flusher.
// ----------------------------------------------------------------------------
package opt_pkg;

    // Parameter defaults
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_PAGES_DEF   = 8;
    localparam int CHUNK_BYTES_DEF = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_PANEL_WIDTH = 2'd0;
    localparam logic [1:0] REG_PAGE_COUNT  = 2'd1;

    // Register reset values
    localparam logic [7:0] WIDTH_RESET = 8'd128;
    localparam logic [3:0] PAGES_RESET = 4'd8;

    // Request types
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_PULL  = 1'b1;

    // Stream bytes
    localparam logic [7:0] CTRL_CMD        = 8'h00;
    localparam logic [7:0] CTRL_DATA       = 8'h40;
    localparam logic [7:0] CMD_COL_WINDOW  = 8'h21;
    localparam logic [7:0] CMD_PAGE_WINDOW = 8'h22;
    localparam logic [7:0] COL_START       = 8'h00;

    // Positions inside the window command packet
    localparam int WIN_CTRL     = 0;
    localparam int WIN_COL_CMD  = 1;
    localparam int WIN_COL_LO   = 2;
    localparam int WIN_COL_HI   = 3;
    localparam int WIN_PAGE_CMD = 4;
    localparam int WINDOW_LEN   = 7;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_FETCH
    } t_state;

    // Next flush stream byte, as seen by the top level
    typedef struct packed {
        logic       is_data;   // byte comes from the frame store
        logic [7:0] data;      // byte when not from the store
        logic       pstart;
        logic       pend;
        logic       fend;
        logic [2:0] page;
        logic [7:0] column;
    } t_flush_out;

endpackage

### src/opt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module opt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/opt_flush_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// opt_flush_seq
// Flush stream sequencer: window packet, then data packets, page by page.
// ----------------------------------------------------------------------------
module opt_flush_seq #(
    parameter int CHUNK_BYTES = opt_pkg::CHUNK_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,   // pull item taken this cycle
    input  logic                i_clear,  // back to idle (register write)
    input  logic [7:0]          i_width,  // effective width, 1..max
    input  logic [3:0]          i_pages,  // effective page count, 1..max
    output opt_pkg::t_flush_out o_next
);
    import opt_pkg::*;

    localparam int POS_MAX = (CHUNK_BYTES > WINDOW_LEN) ? CHUNK_BYTES : WINDOW_LEN;
    localparam int POS_W   = $clog2(POS_MAX + 1);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_cmd, n_cmd;
    logic [2:0]       r_page, n_page;
    logic [7:0]       r_col, n_col;

    logic [POS_W-1:0] pos_inc;
    logic [3:0]       page_inc;
    logic [8:0]       col_inc;
    logic             col_end;
    t_flush_out       fo;

    assign pos_inc  = r_pos + POS_W'(1);
    assign page_inc = {1'b0, r_page} + 4'd1;
    assign col_inc  = {1'b0, r_col} + 9'd1;
    assign col_end  = (col_inc >= {1'b0, i_width});

    always_comb begin
        fo        = '0;
        fo.page   = r_page;
        fo.column = r_col;
        n_pos     = r_pos;
        n_cmd     = r_cmd;
        n_page    = r_page;
        n_col     = r_col;

        if (r_cmd) begin
            case (r_pos)
                POS_W'(WIN_CTRL): begin
                    fo.data   = CTRL_CMD;
                    fo.pstart = 1'b1;
                end
                POS_W'(WIN_COL_CMD):  fo.data = CMD_COL_WINDOW;
                POS_W'(WIN_COL_LO):   fo.data = COL_START;
                POS_W'(WIN_COL_HI):   fo.data = i_width - 8'd1;
                POS_W'(WIN_PAGE_CMD): fo.data = CMD_PAGE_WINDOW;
                default:              fo.data = {5'd0, r_page};
            endcase
            if (pos_inc >= POS_W'(WINDOW_LEN)) begin
                fo.pend = 1'b1;
                n_pos   = '0;
                n_cmd   = 1'b0;
            end else begin
                n_pos = pos_inc;
            end
        end else if (r_pos == '0) begin
            fo.data   = CTRL_DATA;
            fo.pstart = 1'b1;
            n_pos     = POS_W'(1);
        end else begin
            fo.is_data = 1'b1;
            if (r_pos >= POS_W'(CHUNK_BYTES) || col_end) begin
                fo.pend = 1'b1;
                n_pos   = '0;
                if (col_end) begin
                    n_col = '0;
                    n_cmd = 1'b1;
                    if (page_inc >= i_pages) begin
                        fo.fend = 1'b1;
                        n_page  = '0;
                    end else begin
                        n_page = r_page + 3'd1;
                    end
                end else begin
                    n_col = col_inc[7:0];
                end
            end else begin
                n_col = col_inc[7:0];
                n_pos = pos_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_pos  <= '0;
            r_cmd  <= 1'b1;
            r_page <= '0;
            r_col  <= '0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_cmd  <= n_cmd;
            r_page <= n_page;
            r_col  <= n_col;
        end
    end

    assign o_next = fo;

endmodule

### src/oled_page_transpose_flusher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oled_page_transpose_flusher
// Page-mode frame store with row-major pixel writes and a byte flush stream.
// ----------------------------------------------------------------------------
// Write item: busy, then a result strobe (read-modify-write of up to eight
//   page bytes over the single RAM read port); out of panel, status only.
// Pull item: command/control byte strobes the next cycle with no busy time;
//   a page data byte takes one RAM read, busy in ST_FETCH, then strobes.
// Reset: a clearing pass writes zero to all MAX_PAGES*MAX_COLUMNS frame
//   store entries (1024 by default), busy throughout.
// The receiver cannot stall; each result is on the ports for one cycle.
// ----------------------------------------------------------------------------
module oled_page_transpose_flusher #(
    parameter int MAX_COLUMNS = opt_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_PAGES   = opt_pkg::MAX_PAGES_DEF,
    parameter int CHUNK_BYTES = opt_pkg::CHUNK_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       i_start,
    output logic       o_busy,
    input  logic       i_req_type,
    input  logic [5:0] i_pixel_row,
    input  logic [3:0] i_column_group,
    input  logic [7:0] i_pixel_bits,
    // result channel
    output logic       o_valid,
    output logic       o_status,
    output logic [7:0] o_bus_byte,
    output logic       o_packet_start,
    output logic       o_packet_end,
    output logic       o_frame_end,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import opt_pkg::*;

    localparam int DEPTH  = MAX_PAGES * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_COLUMNS);

    // Store address: page-major, one byte per column.
    function automatic logic [ADDR_W-1:0] f_addr(input logic [2:0] page,
                                                 input logic [7:0] col);
        return ADDR_W'(page * MAX_COLUMNS) + ADDR_W'(col[COL_W-1:0]);
    endfunction

    // ---------------- configuration registers ----------------
    logic [7:0] r_cfg_width;
    logic [3:0] r_cfg_pages;
    logic [7:0] eff_width;
    logic [3:0] eff_pages;
    logic       cfg_hit;

    assign cfg_hit = i_cfg_we &&
                     (i_cfg_index == REG_PANEL_WIDTH || i_cfg_index == REG_PAGE_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width <= WIDTH_RESET;
            r_cfg_pages <= PAGES_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PANEL_WIDTH: r_cfg_width <= i_cfg_data;
                REG_PAGE_COUNT:  r_cfg_pages <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Saturate registers to the supported panel size; zero counts as one.
    always_comb begin
        eff_width = r_cfg_width;
        if (r_cfg_width == 8'd0) begin
            eff_width = 8'd1;
        end else if ({1'b0, r_cfg_width} > 9'(MAX_COLUMNS)) begin
            eff_width = 8'(MAX_COLUMNS);
        end
        eff_pages = r_cfg_pages;
        if (r_cfg_pages == 4'd0) begin
            eff_pages = 4'd1;
        end else if (r_cfg_pages > 4'(MAX_PAGES)) begin
            eff_pages = 4'(MAX_PAGES);
        end
    end

    // ---------------- flush sequencer ----------------
    t_flush_out fo;
    logic       seq_step;

    opt_flush_seq #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (seq_step),
        .i_clear (cfg_hit),
        .i_width (eff_width),
        .i_pages (eff_pages),
        .o_next  (fo)
    );

    // ---------------- frame store ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    opt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- control ----------------
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [3:0]        r_k, n_k;           // write phase: column slot 0..8
    logic              r_rd_ok, n_rd_ok;   // a read was issued last cycle
    logic              r_valid, n_valid;

    // write item payload
    logic [2:0]        r_wr_page, n_wr_page;
    logic [7:0]        r_wr_base, n_wr_base;
    logic [7:0]        r_wr_bits, n_wr_bits;
    logic [7:0]        r_wr_mask, n_wr_mask;
    logic [ADDR_W-1:0] r_prev_addr, n_prev_addr;
    logic              r_prev_bit, n_prev_bit;

    // result payload
    logic              r_status, n_status;
    logic [7:0]        r_byte, n_byte;
    logic              r_pstart, n_pstart;
    logic              r_pend, n_pend;
    logic              r_fend, n_fend;

    logic              accept;
    logic              out_of_panel;
    logic [7:0]        col_k;
    logic              rd_ok;

    assign accept       = i_start && (r_state == ST_IDLE);
    // page of the row beyond the panel, or the group starts past the width
    assign out_of_panel = ({1'b0, i_pixel_row[5:3]} >= eff_pages) ||
                          ({1'b0, i_column_group, 3'd0} >= eff_width);
    assign col_k        = r_wr_base + {4'd0, r_k};
    assign rd_ok        = !r_k[3] && (col_k < eff_width);

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_k         = r_k;
        n_rd_ok     = r_rd_ok;
        n_valid     = 1'b0;
        n_wr_page   = r_wr_page;
        n_wr_base   = r_wr_base;
        n_wr_bits   = r_wr_bits;
        n_wr_mask   = r_wr_mask;
        n_prev_addr = r_prev_addr;
        n_prev_bit  = r_prev_bit;
        n_status    = r_status;
        n_byte      = r_byte;
        n_pstart    = r_pstart;
        n_pend      = r_pend;
        n_fend      = r_fend;
        seq_step    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;

        unique case (r_state)
            // zero the whole store after reset, one entry a cycle
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + ADDR_W'(1);
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_WRITE) begin
                        n_status = out_of_panel;
                        n_byte   = '0;
                        n_pstart = 1'b0;
                        n_pend   = 1'b0;
                        n_fend   = 1'b0;
                        if (out_of_panel) begin
                            n_valid = 1'b1;
                        end else begin
                            n_state   = ST_WRITE;
                            n_k       = '0;
                            n_rd_ok   = 1'b0;
                            n_wr_page = i_pixel_row[5:3];
                            n_wr_base = {1'b0, i_column_group, 3'd0};
                            n_wr_bits = i_pixel_bits;
                            n_wr_mask = 8'd1 << i_pixel_row[2:0];
                        end
                    end else begin
                        seq_step = 1'b1;
                        n_status = 1'b0;
                        n_byte   = fo.data;
                        n_pstart = fo.pstart;
                        n_pend   = fo.pend;
                        n_fend   = fo.fend;
                        if (fo.is_data) begin
                            // page byte: fetch here, deliver from ST_FETCH
                            ram_re    = 1'b1;
                            ram_raddr = f_addr(fo.page, fo.column);
                            n_state   = ST_FETCH;
                        end else begin
                            n_valid = 1'b1;
                        end
                    end
                end
            end

            ST_FETCH: begin
                n_byte  = ram_rdata;
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end

            // read column k while writing back column k-1
            ST_WRITE: begin
                if (rd_ok) begin
                    ram_re    = 1'b1;
                    ram_raddr = f_addr(r_wr_page, col_k);
                end
                if (r_rd_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_prev_addr;
                    ram_wdata = r_prev_bit ? (ram_rdata | r_wr_mask)
                                           : (ram_rdata & ~r_wr_mask);
                end
                n_prev_addr = f_addr(r_wr_page, col_k);
                n_prev_bit  = r_wr_bits[r_k[2:0]];
                n_rd_ok     = rd_ok;
                if (r_k[3]) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_k        <= '0;
            r_rd_ok    <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_k        <= n_k;
            r_rd_ok    <= n_rd_ok;
            r_valid    <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_wr_page   <= n_wr_page;
        r_wr_base   <= n_wr_base;
        r_wr_bits   <= n_wr_bits;
        r_wr_mask   <= n_wr_mask;
        r_prev_addr <= n_prev_addr;
        r_prev_bit  <= n_prev_bit;
        r_status    <= n_status;
        r_byte      <= n_byte;
        r_pstart    <= n_pstart;
        r_pend      <= n_pend;
        r_fend      <= n_fend;
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_bus_byte     = r_byte;
    assign o_packet_start = r_pstart;
    assign o_packet_end   = r_pend;
    assign o_frame_end    = r_fend;

endmodule
